/* sv/ctc_pkg.sv */
`default_nettype none
package ctc_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 16;
    localparam int TABLE_DEPTH_DEF   = 16;

    localparam logic [2:0] CLS_DELIM = 3'd0;
    localparam logic [2:0] CLS_OPER  = 3'd1;
    localparam logic [2:0] CLS_IDENT = 3'd2;
    localparam logic [2:0] CLS_KEYW  = 3'd3;
    localparam logic [2:0] CLS_CONST = 3'd4;
    localparam logic [2:0] CLS_LIT   = 3'd5;

    localparam logic [1:0] GRP_DELIM = 2'd0;
    localparam logic [1:0] GRP_OPER  = 2'd1;
    localparam logic [1:0] GRP_IDENT = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_LONG  = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;
    localparam logic [1:0] ERR_UNTRM = 2'd3;

    // Requests from the lexer to the dedup table.
    typedef struct packed {
        logic       start;
        logic       clear;
        logic [1:0] group;
    } ctc_req_t;

    typedef struct packed {
        logic done;
        logic first_seen;
        logic full;
    } ctc_rsp_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
               is_digit(c) || (c == 8'h5f) || (c == 8'h2e);
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2a) || (c == 8'h2f) ||
               (c == 8'h3d) || (c == 8'h3c) || (c == 8'h3e) || (c == 8'h25);
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return (c == 8'h7d) || (c == 8'h7b) || (c == 8'h3b) || (c == 8'h28) ||
               (c == 8'h29) || (c == 8'h5b) || (c == 8'h5d) || (c == 8'h2c);
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return c == 8'h22;
    endfunction

    // first5 holds the first five token bytes, first byte lowest.
    function automatic logic is_keyword(input logic [39:0] first5, input logic [5:0] len);
        logic r;
        r = ((len == 6'd3) && (first5[23:0] == 24'h746e69)) ||
            ((len == 6'd4) && (first5[31:0] == 32'h64696f76)) ||
            ((len == 6'd4) && (first5[31:0] == 32'h6e69616d)) ||
            ((len == 6'd4) && (first5[31:0] == 32'h72616863)) ||
            ((len == 6'd5) && (first5 == 40'h74616f6c66));
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/ctc_dedup.sv */
`default_nettype none
module ctc_dedup
    import ctc_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
    parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire ctc_req_t                               req,
    input  wire logic [MAX_TOKEN_LEN*8-1:0]             chars,
    input  wire logic [$clog2(MAX_TOKEN_LEN+1)-1:0]     len,
    output ctc_rsp_t                                    rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int EW    = MAX_TOKEN_LEN * 8 + CNT_W + 2;

    logic [EW-1:0]    mem [TABLE_DEPTH];
    logic [EW-1:0]    rd_data_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic             busy_reg;
    logic [IDX_W:0]   ptr_reg;
    logic             chk_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             done_reg;
    logic             first_reg;
    logic             full_reg;

    logic [MAX_TOKEN_LEN*8-1:0] ent_chars;
    logic [CNT_W-1:0] ent_len;
    logic [1:0]       ent_grp;
    logic             bytes_eq;
    logic             ent_valid;
    logic             hit;
    logic             is_free;
    logic             is_last;
    logic             have_slot;
    logic [IDX_W-1:0] slot;
    logic             stop;
    logic             issue;
    logic             wr_en;

    assign ent_chars = rd_data_reg[MAX_TOKEN_LEN*8-1:0];
    assign ent_len   = rd_data_reg[MAX_TOKEN_LEN*8 +: CNT_W];
    assign ent_grp   = rd_data_reg[EW-1 -: 2];

    always_comb
    begin
        bytes_eq = 1'b1;
        for (int i = 0; i < MAX_TOKEN_LEN; i++)
        begin
            if ((CNT_W'(i) < len) && (chars[i*8 +: 8] != ent_chars[i*8 +: 8]))
            begin
                bytes_eq = 1'b0;
            end
        end
    end

    assign ent_valid = valid_reg[chk_idx_reg];
    assign hit       = chk_reg && ent_valid && (ent_grp == req.group) &&
                       (ent_len == len) && bytes_eq;
    assign is_free   = chk_reg && !ent_valid;
    assign is_last   = chk_reg && (chk_idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign have_slot = free_found_reg || is_free;
    assign slot      = free_found_reg ? free_idx_reg : chk_idx_reg;
    assign stop      = hit || is_last;
    assign issue     = busy_reg && !stop && (ptr_reg < (IDX_W+1)'(TABLE_DEPTH));
    assign wr_en     = busy_reg && is_last && !hit && have_slot;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[slot] <= {req.group, len, chars};
        end
        if (issue)
        begin
            rd_data_reg <= mem[ptr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            busy_reg       <= 1'b0;
            ptr_reg        <= '0;
            chk_reg        <= 1'b0;
            chk_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            done_reg       <= 1'b0;
            first_reg      <= 1'b0;
            full_reg       <= 1'b0;
        end
        else
        begin
            done_reg  <= busy_reg && stop;
            first_reg <= !hit;
            full_reg  <= !hit && !have_slot;
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[slot] <= 1'b1;
            end
            if (req.start)
            begin
                busy_reg       <= 1'b1;
                ptr_reg        <= '0;
                chk_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (stop)
                begin
                    busy_reg <= 1'b0;
                    chk_reg  <= 1'b0;
                end
                else
                begin
                    chk_reg     <= issue;
                    chk_idx_reg <= ptr_reg[IDX_W-1:0];
                    if (issue)
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                    if (is_free && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= chk_idx_reg;
                    end
                end
            end
        end
    end

    assign rsp.done       = done_reg;
    assign rsp.first_seen = first_reg;
    assign rsp.full       = full_reg;

    a_full_is_first: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && full_reg |-> first_reg)
        else $error("full table reported on a hit");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("lookup started while a walk is running");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("walk still running after its result");
    a_check_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        chk_reg |-> busy_reg)
        else $error("entry compared outside a walk");

endmodule
`default_nettype wire

/* sv/c_subset_token_classifier.sv */
`default_nettype none
// Channel   Direction  tdata (low bit up)                         tlast
// s_axis    in         ch[7:0]                                    end_of_string
// m_axis    out        class[2:0] length[7:3] head[71:8]          last_of_run
//                      first_seen[72] error_code[74:73]
//
// A character that finishes no token goes from IDLE to EOS, through PHB unless it extends a run;
// FIN follows when it ends a string. Each token that is checked for repeats walks the dedup
// table: the table memory is read one entry per cycle, stopping early on a hit.
// Literals skip the table. Reset clears the lexer state and every table valid bit at once.
// A stalled output holds the next token back.
module c_subset_token_classifier
    import ctc_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
    parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // ch
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // token_class, token_length, token_head,
                                             // first_seen, error_code, zero fill
    output logic             m_axis_tlast
);

    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int PTR_W = $clog2(MAX_TOKEN_LEN);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PHB  = 3'd1;
    localparam logic [2:0] ST_EOS  = 3'd2;
    localparam logic [2:0] ST_CLS  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_IDENT = 2'd1;
    localparam logic [1:0] MODE_OPER  = 2'd2;
    localparam logic [1:0] MODE_LIT   = 2'd3;

    localparam logic [1:0] KIND_RUN   = 2'd0;
    localparam logic [1:0] KIND_DELIM = 2'd1;
    localparam logic [1:0] KIND_LIT   = 2'd2;
    localparam logic [1:0] KIND_UNTRM = 2'd3;

    logic [2:0]       state_reg, state_next;
    logic [2:0]       ret_reg, ret_next;
    logic [1:0]       mode_reg, mode_next;
    logic [1:0]       kind_reg, kind_next;
    logic             last_reg, last_next;
    logic [7:0]       c_reg, c_next;
    logic             eos_reg, eos_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             long_reg, long_next;
    logic [7:0]       tok_reg [MAX_TOKEN_LEN];
    logic [2:0]       cls_reg, cls_next;
    logic             first_reg, first_next;
    logic             full_reg, full_next;
    logic             out_valid_reg;
    logic [79:0]      out_data_reg;
    logic             out_last_reg;

    logic             push;
    logic [7:0]       push_c;
    logic             load_out;
    logic             tok_clear;
    logic [63:0]      head;
    logic [39:0]      first5;
    logic [MAX_TOKEN_LEN*8-1:0] chars_flat;
    logic [1:0]       err;
    ctc_req_t         req;
    ctc_rsp_t         rsp;

    logic             in_acc;
    logic             cont;
    logic [7:0]       c_in;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign c_in   = s_axis_tdata;
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign cont = (mode_reg == MODE_LIT) ||
                  ((mode_reg == MODE_IDENT) && is_ident(c_in)) ||
                  ((mode_reg == MODE_OPER) && is_oper(c_in));

    always_comb
    begin
        head = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (CNT_W'(i) < count_reg)
            begin
                head[i*8 +: 8] = tok_reg[i];
            end
        end
        for (int i = 0; i < 5; i++)
        begin
            first5[i*8 +: 8] = tok_reg[i];
        end
        for (int i = 0; i < MAX_TOKEN_LEN; i++)
        begin
            chars_flat[i*8 +: 8] = tok_reg[i];
        end
    end

    always_comb
    begin
        if (kind_reg == KIND_UNTRM)
        begin
            err = ERR_UNTRM;
        end
        else if (full_reg)
        begin
            err = ERR_FULL;
        end
        else if (long_reg)
        begin
            err = ERR_LONG;
        end
        else
        begin
            err = ERR_NONE;
        end
    end

    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        mode_next  = mode_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        c_next     = c_reg;
        eos_next   = eos_reg;
        cls_next   = cls_reg;
        first_next = first_reg;
        full_next  = full_reg;
        push       = 1'b0;
        push_c     = c_reg;
        tok_clear  = 1'b0;
        req.start  = 1'b0;
        req.clear  = 1'b0;
        req.group  = (cls_reg == CLS_DELIM) ? GRP_DELIM :
                     ((cls_reg == CLS_OPER) ? GRP_OPER : GRP_IDENT);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    c_next   = c_in;
                    eos_next = s_axis_tlast;
                    push_c   = c_in;
                    if (cont)
                    begin
                        push = 1'b1;
                        if ((mode_reg == MODE_LIT) && is_quote(c_in))
                        begin
                            kind_next  = KIND_LIT;
                            last_next  = 1'b1;
                            ret_next   = ST_EOS;
                            state_next = ST_CLS;
                        end
                        else
                        begin
                            state_next = ST_EOS;
                        end
                    end
                    else if (mode_reg != MODE_IDLE)
                    begin
                        // The open run closes; more tokens may follow from this character.
                        kind_next  = KIND_RUN;
                        last_next  = !(is_delim(c_in) || (s_axis_tlast &&
                                     (is_ident(c_in) || is_oper(c_in) || is_quote(c_in))));
                        ret_next   = ST_PHB;
                        state_next = ST_CLS;
                    end
                    else
                    begin
                        state_next = ST_PHB;
                    end
                end
            end
            ST_PHB:
            begin
                state_next = ST_EOS;
                if (is_ident(c_reg))
                begin
                    mode_next = MODE_IDENT;
                    push      = 1'b1;
                end
                else if (is_oper(c_reg))
                begin
                    mode_next = MODE_OPER;
                    push      = 1'b1;
                end
                else if (is_quote(c_reg))
                begin
                    mode_next = MODE_LIT;
                    push      = 1'b1;
                end
                else if (is_delim(c_reg))
                begin
                    push       = 1'b1;
                    kind_next  = KIND_DELIM;
                    last_next  = 1'b1;
                    ret_next   = ST_EOS;
                    state_next = ST_CLS;
                end
            end
            ST_EOS:
            begin
                if (!eos_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (mode_reg != MODE_IDLE)
                begin
                    kind_next  = (mode_reg == MODE_LIT) ? KIND_UNTRM : KIND_RUN;
                    last_next  = 1'b1;
                    ret_next   = ST_FIN;
                    state_next = ST_CLS;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_CLS:
            begin
                if (kind_reg == KIND_DELIM)
                begin
                    cls_next = CLS_DELIM;
                end
                else if ((kind_reg == KIND_LIT) || (kind_reg == KIND_UNTRM))
                begin
                    cls_next = CLS_LIT;
                end
                else if (mode_reg == MODE_OPER)
                begin
                    cls_next = CLS_OPER;
                end
                else if (!long_reg && is_keyword(first5, 6'(count_reg)))
                begin
                    cls_next = CLS_KEYW;
                end
                else if ((count_reg != '0) && is_digit(tok_reg[0]))
                begin
                    cls_next = CLS_CONST;
                end
                else
                begin
                    cls_next = CLS_IDENT;
                end
                if (cls_next == CLS_LIT)
                begin
                    first_next = 1'b1;
                    full_next  = 1'b0;
                    state_next = ST_OUT;
                end
                else
                begin
                    req.start  = 1'b1;
                    req.group  = (cls_next == CLS_DELIM) ? GRP_DELIM :
                                 ((cls_next == CLS_OPER) ? GRP_OPER : GRP_IDENT);
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (rsp.done)
                begin
                    first_next = rsp.first_seen;
                    full_next  = rsp.full;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    tok_clear  = 1'b1;
                    mode_next  = MODE_IDLE;
                    state_next = ret_reg;
                end
            end
            ST_FIN:
            begin
                req.clear  = 1'b1;
                tok_clear  = 1'b1;
                mode_next  = MODE_IDLE;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        long_next  = long_reg;
        if (tok_clear)
        begin
            count_next = '0;
            long_next  = 1'b0;
        end
        else if (push)
        begin
            if (count_reg < CNT_W'(MAX_TOKEN_LEN))
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                long_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !tok_clear && (count_reg < CNT_W'(MAX_TOKEN_LEN)))
        begin
            tok_reg[count_reg[PTR_W-1:0]] <= push_c;
        end
        if (load_out)
        begin
            out_data_reg <= {5'd0, err, first_reg, head, 5'(count_reg), cls_reg};
            out_last_reg <= last_reg;
        end
        c_reg     <= c_next;
        eos_reg   <= eos_next;
        kind_reg  <= kind_next;
        last_reg  <= last_next;
        ret_reg   <= ret_next;
        cls_reg   <= cls_next;
        first_reg <= first_next;
        full_reg  <= full_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_IDLE;
            count_reg     <= '0;
            long_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            count_reg <= count_next;
            long_reg  <= long_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    ctc_dedup #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .TABLE_DEPTH   (TABLE_DEPTH)
    ) u_dedup (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .chars (chars_flat),
        .len   (count_reg),
        .rsp   (rsp)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire
